FILE: rtl/vfd_pkg.sv
// ---------------------------------------------------------------------------
// vfd_pkg: shared types and constants of the optical link frame deframer
// Phase codes, status codes, register indexes and the result job record.
// ---------------------------------------------------------------------------
package vfd_pkg;

    localparam int FRAME_CELLS = 8;
    localparam int CELL_W      = 3;
    localparam int FRAME_W     = FRAME_CELLS * CELL_W;
    localparam int BYTE_W      = 8;
    localparam int STAT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_W     = 40;
    localparam int CNT_W       = 2;

    localparam logic [FRAME_W-1:0] FRAME_ONES = {FRAME_W{1'b1}};
    localparam logic [CNT_W-1:0]   MAX_BYTES  = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_END    = 2'd3
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_UNEXP_END  = 3'd2,
        ST_UNEXP_REP  = 3'd3,
        ST_MISSING_END = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START   = 3'd0,
        REG_END     = 3'd1,
        REG_REPEAT  = 3'd2,
        REG_ESCAPE  = 3'd3,
        REG_ESC_ESC = 3'd4,
        REG_MAX_LEN = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic               is_stat;
        t_status            code;
        logic [FRAME_W-1:0] len;
        logic [FRAME_W-1:0] word;
        logic [CNT_W-1:0]   cnt;
    } t_job;

endpackage

FILE: rtl/vlc_frame_deframer.sv
// ---------------------------------------------------------------------------
// vlc_frame_deframer: frame-level deframer for an optical link
// Hunts for START, takes a length frame, turns data frames into payload
// bytes with ESCAPE and REPEAT handling, and closes each message with a
// status result.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: frame_cells
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata, tuser: kind, tlast: last
//   cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// A frame is decoded in the cycle it is accepted; its results (zero to three)
// leave from the job register one per cycle while m_axis_tready is high.
// The next frame is accepted in the cycle the last result of the previous
// one is taken. Reset is synchronous, active low, and returns to hunting.
// Configuration writes are always taken.
// ---------------------------------------------------------------------------
module vlc_frame_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [vfd_pkg::FRAME_W-1:0]     s_axis_tdata,   // [23:0] frame_cells
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [vfd_pkg::TDATA_W-1:0]     m_axis_tdata,   // [7:0] data_byte,
                                                            // [10:8] status_code,
                                                            // [34:11] message_length
    output logic                            m_axis_tuser,   // [0] kind
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vfd_pkg::FRAME_W-1:0]     i_cfg_data
);
    import vfd_pkg::*;

    logic [FRAME_W-1:0] r_start, r_end, r_repeat, r_escape, r_esc_esc, r_max_len;

    t_phase             r_phase, n_phase;
    logic               r_esc_pend, n_esc_pend;
    logic [FRAME_W-1:0] r_expected, n_expected;
    logic [FRAME_W-1:0] r_delivered, n_delivered;
    logic [FRAME_W-1:0] r_prev, n_prev;
    logic               r_first_seen, n_first_seen;

    t_job               r_job, n_job;
    logic               r_busy;
    logic [CNT_W-1:0]   r_idx;

    logic               in_acc, out_acc, job_load;
    logic [FRAME_W-1:0] f, remaining;
    logic [CNT_W-1:0]   count;
    logic [4:0]         shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_end     <= '0;
            r_repeat  <= '0;
            r_escape  <= '0;
            r_esc_esc <= '0;
            r_max_len <= FRAME_ONES;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START:   r_start   <= i_cfg_data;
                REG_END:     r_end     <= i_cfg_data;
                REG_REPEAT:  r_repeat  <= i_cfg_data;
                REG_ESCAPE:  r_escape  <= i_cfg_data;
                REG_ESC_ESC: r_esc_esc <= i_cfg_data;
                REG_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output side
    assign m_axis_tvalid = r_busy;
    assign m_axis_tuser  = r_job.is_stat;
    assign m_axis_tlast  = r_job.is_stat || (r_idx == r_job.cnt - 2'd1);
    assign shift         = 5'd16 - {r_idx, 3'b000};

    always_comb begin
        m_axis_tdata = '0;
        if (r_job.is_stat) begin
            m_axis_tdata[10:8]  = r_job.code;
            m_axis_tdata[34:11] = r_job.len;
        end else begin
            m_axis_tdata[7:0] = BYTE_W'(r_job.word >> shift);
        end
    end

    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_busy || (m_axis_tready && m_axis_tlast);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // decode
    assign f         = s_axis_tdata;
    assign remaining = r_expected - r_delivered;
    assign count     = (remaining < FRAME_W'(MAX_BYTES)) ? remaining[CNT_W-1:0] : MAX_BYTES;

    always_comb begin
        n_phase      = r_phase;
        n_esc_pend   = r_esc_pend;
        n_expected   = r_expected;
        n_delivered  = r_delivered;
        n_prev       = r_prev;
        n_first_seen = r_first_seen;
        job_load     = 1'b0;
        n_job        = '{is_stat: 1'b1, code: ST_OK, len: '0, word: f, cnt: count};

        case (r_phase)
            PH_HUNT: begin
                if (f == r_start) n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (f > r_max_len) begin
                    job_load   = 1'b1;
                    n_job.code = ST_TOO_LONG;
                    n_phase    = PH_HUNT;
                    n_esc_pend = 1'b0;
                end else begin
                    n_expected   = f;
                    n_delivered  = '0;
                    n_first_seen = 1'b0;
                    n_esc_pend   = 1'b0;
                    n_phase      = (f == '0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_esc_pend) begin
                    n_esc_pend    = 1'b0;
                    job_load      = 1'b1;
                    n_job.is_stat = 1'b0;
                    if (f == r_esc_esc) n_job.word = r_escape;
                end else if (f == r_end) begin
                    job_load   = 1'b1;
                    n_job.code = ST_UNEXP_END;
                    n_phase    = PH_HUNT;
                end else if (!r_first_seen && f == r_repeat) begin
                    job_load   = 1'b1;
                    n_job.code = ST_UNEXP_REP;
                    n_phase    = PH_HUNT;
                end else if (f == r_escape) begin
                    n_esc_pend = 1'b1;
                end else begin
                    job_load      = 1'b1;
                    n_job.is_stat = 1'b0;
                    if (f == r_repeat) n_job.word = r_prev;
                end
                if (job_load && !n_job.is_stat) begin
                    n_delivered  = r_delivered + FRAME_W'(count);
                    n_prev       = f;
                    n_first_seen = 1'b1;
                    if (n_delivered >= r_expected) n_phase = PH_END;
                end
            end
            PH_END: begin
                job_load   = 1'b1;
                n_phase    = PH_HUNT;
                n_esc_pend = 1'b0;
                if (f == r_end || (f == r_repeat && r_first_seen && r_prev == r_end)) begin
                    n_job.code = ST_OK;
                    n_job.len  = r_delivered;
                end else begin
                    n_job.code = ST_MISSING_END;
                end
            end
            default: begin
                n_phase    = PH_HUNT;
                n_esc_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_esc_pend   <= 1'b0;
            r_expected   <= '0;
            r_delivered  <= '0;
            r_prev       <= '0;
            r_first_seen <= 1'b0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (in_acc) begin
                r_phase      <= n_phase;
                r_esc_pend   <= n_esc_pend;
                r_expected   <= n_expected;
                r_delivered  <= n_delivered;
                r_prev       <= n_prev;
                r_first_seen <= n_first_seen;
            end
            if (in_acc && job_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_acc) begin
                if (m_axis_tlast) r_busy <= 1'b0;
                else              r_idx  <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && job_load) r_job <= n_job;
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.is_stat) |-> (r_idx < r_job.cnt))
        else $error("byte index beyond byte count");

    a_data_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_delivered < r_expected))
        else $error("data phase with no bytes remaining");

    a_escape_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_pend |-> (r_phase == PH_DATA))
        else $error("escape pending outside data phase");

    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.is_stat && r_job.len != '0) |-> (r_job.code == ST_OK))
        else $error("message length on an error status");

endmodule
